// ===== hdl/gated_pulse_train_generator_defines.svh =====
// ----------------------------------------------------------------------------
// gated pulse train generator - assertion macros
// shared check forms for the pulse train generator
// ----------------------------------------------------------------------------
`ifndef GATED_PULSE_TRAIN_GENERATOR_DEFINES_SVH
`define GATED_PULSE_TRAIN_GENERATOR_DEFINES_SVH

// check sampled on aclk, off while reset is held
`define GPTG_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check sampled on aclk at every edge, reset included
`define GPTG_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/gptg_pkg.sv =====
// ----------------------------------------------------------------------------
// gptg_pkg
// types, event codes and the period table of the pulse train generator
// ----------------------------------------------------------------------------
package gptg_pkg;

    localparam int SET_W     = 8;
    localparam int ELAPSED_W = 11;
    localparam int PERIOD_W  = 11;
    localparam int FRAC_BITS = 43;
    localparam int ROM_DEPTH = 256;

    localparam logic [PERIOD_W-1:0] PERIOD_MIN = 11'd21;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX = 11'd1163;

    typedef enum logic [1:0] {
        FUNC_SWEEP       = 2'd0,
        FUNC_GATE_TICK   = 2'd1,
        FUNC_PERIOD_TICK = 2'd2
    } func_t;

    typedef struct packed {
        func_t            func;
        logic [SET_W-1:0] pot_off;
        logic [SET_W-1:0] pot_on;
        logic [SET_W-1:0] pot_rate;
    } item_t;

    typedef struct packed {
        logic [2:0]          changed_mask;
        logic [PERIOD_W-1:0] period_ms;
        logic [SET_W-1:0]    on_value;
        logic [SET_W-1:0]    off_value;
        logic                gate_is_on;
        logic                fire_pulse;
    } result_t;

    typedef logic [ROM_DEPTH-1:0][PERIOD_W-1:0] period_rom_t;

    // entry r = 20 + floor(1.028^(255-r)), stepped in 43-bit fixed point
    function automatic period_rom_t build_period_rom();
        period_rom_t     rom;
        longint unsigned v;
        int              k;
        v = 64'd1 << FRAC_BITS;
        for (k = 0; k < ROM_DEPTH; k++) begin
            rom[8'(ROM_DEPTH - 1 - k)] = PERIOD_W'(64'd20 + (v >> FRAC_BITS));
            v = (v * 64'd257) / 64'd250;
        end
        return rom;
    endfunction

    localparam period_rom_t PERIOD_ROM = build_period_rom();

endpackage

// ===== hdl/gptg_sweep.sv =====
// ----------------------------------------------------------------------------
// gptg_sweep
// one setting update from a pot sample with a dead band and rounding to 5
// ----------------------------------------------------------------------------
module gptg_sweep (
    input  logic [gptg_pkg::SET_W-1:0] setting,
    input  logic [gptg_pkg::SET_W-1:0] sample,
    output logic [gptg_pkg::SET_W-1:0] setting_next,
    output logic                       changed
);
    import gptg_pkg::*;

    logic [SET_W-1:0] diff;
    logic [SET_W:0]   biased;
    logic [16:0]      scaled;
    logic [5:0]       quot;
    logic [SET_W-1:0] rounded;

    always_comb begin
        diff    = (setting > sample) ? (setting - sample) : (sample - setting);
        biased  = {1'b0, sample} + 9'd2;
        // divide by 5 via reciprocal 205/1024, exact for values up to 257
        scaled  = 17'(biased) * 17'd205;
        quot    = scaled[15:10];
        rounded = {quot, 2'b00} + {2'b00, quot};
        changed = (diff > 8'd4);
        setting_next = changed ? rounded : setting;
    end

endmodule

// ===== hdl/gptg_core.sv =====
// ----------------------------------------------------------------------------
// gptg_core
// settings, burst gate, period timer and the result of one event
// ----------------------------------------------------------------------------
module gptg_core #(
    parameter int PERIOD_STEP_MS = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  gptg_pkg::item_t   item,
    output gptg_pkg::result_t result
);
    import gptg_pkg::*;

    logic [SET_W-1:0]     off_setting_reg, off_setting_next;
    logic [SET_W-1:0]     on_setting_reg, on_setting_next;
    logic [SET_W-1:0]     rate_setting_reg, rate_setting_next;
    logic                 gate_reg, gate_next;
    logic [SET_W-1:0]     on_count_reg, on_count_next;
    logic [SET_W-1:0]     off_count_reg, off_count_next;
    logic [ELAPSED_W-1:0] elapsed_reg, elapsed_next;

    logic [SET_W-1:0]     sw_off, sw_on, sw_rate;
    logic                 ch_off, ch_on, ch_rate;
    logic [SET_W-1:0]     count_inc;
    logic [ELAPSED_W:0]   elapsed_sum;
    logic                 fire;
    logic [2:0]           mask;

    gptg_sweep u_sweep_off (
        .setting(off_setting_reg), .sample(item.pot_off),
        .setting_next(sw_off), .changed(ch_off)
    );
    gptg_sweep u_sweep_on (
        .setting(on_setting_reg), .sample(item.pot_on),
        .setting_next(sw_on), .changed(ch_on)
    );
    gptg_sweep u_sweep_rate (
        .setting(rate_setting_reg), .sample(item.pot_rate),
        .setting_next(sw_rate), .changed(ch_rate)
    );

    always_comb begin
        off_setting_next  = off_setting_reg;
        on_setting_next   = on_setting_reg;
        rate_setting_next = rate_setting_reg;
        gate_next         = gate_reg;
        on_count_next     = on_count_reg;
        off_count_next    = off_count_reg;
        elapsed_next      = elapsed_reg;
        fire              = 1'b0;
        mask              = 3'b000;
        count_inc         = (gate_reg ? on_count_reg : off_count_reg) + 8'd1;
        elapsed_sum       = {1'b0, elapsed_reg} + (ELAPSED_W+1)'(PERIOD_STEP_MS);

        case (item.func)
            FUNC_SWEEP: begin
                off_setting_next  = sw_off;
                on_setting_next   = sw_on;
                rate_setting_next = sw_rate;
                mask              = {ch_rate, ch_on, ch_off};
            end
            FUNC_GATE_TICK: begin
                if (gate_reg) begin
                    on_count_next = count_inc;
                    if (count_inc > on_setting_reg) begin
                        gate_next     = 1'b0;
                        on_count_next = '0;
                    end
                end else begin
                    off_count_next = count_inc;
                    if (count_inc > off_setting_reg) begin
                        gate_next      = 1'b1;
                        off_count_next = '0;
                    end
                end
            end
            FUNC_PERIOD_TICK: begin
                elapsed_next = elapsed_sum[ELAPSED_W-1:0];
                if (elapsed_sum >= {1'b0, PERIOD_ROM[rate_setting_reg]}) begin
                    elapsed_next = '0;
                    fire         = gate_reg;
                end
            end
            default: begin
                // unused event kind leaves the state alone
            end
        endcase

        result.fire_pulse   = fire;
        result.gate_is_on   = gate_next;
        result.off_value    = off_setting_next;
        result.on_value     = on_setting_next;
        result.period_ms    = PERIOD_ROM[rate_setting_next];
        result.changed_mask = mask;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            off_setting_reg  <= '0;
            on_setting_reg   <= '0;
            rate_setting_reg <= '0;
            gate_reg         <= 1'b0;
            on_count_reg     <= '0;
            off_count_reg    <= '0;
            elapsed_reg      <= '0;
        end else if (step_en) begin
            off_setting_reg  <= off_setting_next;
            on_setting_reg   <= on_setting_next;
            rate_setting_reg <= rate_setting_next;
            gate_reg         <= gate_next;
            on_count_reg     <= on_count_next;
            off_count_reg    <= off_count_next;
            elapsed_reg      <= elapsed_next;
        end
    end

endmodule

// ===== hdl/gated_pulse_train_generator.sv =====
// ----------------------------------------------------------------------------
// gated_pulse_train_generator
// pulse train generator with an on/off burst gate, set up from pot samples
// ----------------------------------------------------------------------------
// Usage: each item on the s_ channel is one event; s_tuser gives its kind
// (pot sweep, gate tick, period tick) and s_tdata the three pot samples.
// Every item yields exactly one result on the m_ channel with the fire flag,
// gate state, current settings, pulse period in ms and the sweep change mask.
// Path: an item accepted into the input register passes the logic, and its
// result is then held in the result register that drives m_tvalid.
// Throughput: one item per cycle; the input register feeds a single pass of
// logic (sweep rounding, gate counters, period table lookup) into the result
// register, and both move together whenever the result register is free.
// Reset (aresetn low, synchronous) clears all settings, counters, the gate
// and the elapsed timer, and empties both registers.
// When m_tready is low a result waits in the result register; one more item
// is taken into the input register, then s_tready drops until the result
// leaves.
// ----------------------------------------------------------------------------
module gated_pulse_train_generator #(
    parameter int PERIOD_STEP_MS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // pot_off[7:0], pot_on[15:8], pot_rate[23:16]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    // fire_pulse[0], gate_is_on[1], off_value[9:2], on_value[17:10],
    // period_ms[28:18], changed_mask[31:29]
    output logic [31:0] m_tdata
);
    import gptg_pkg::*;

`include "gated_pulse_train_generator_defines.svh"

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_data_reg;
    result_t core_result;
    logic    advance;
    logic    s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    gptg_core #(
        .PERIOD_STEP_MS(PERIOD_STEP_MS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_item_reg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_item_reg <= '{func:     func_t'(s_tuser),
                             pot_off:  s_tdata[7:0],
                             pot_on:   s_tdata[15:8],
                             pot_rate: s_tdata[23:16]};
        end
        if (advance) begin
            out_data_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // a pulse only starts while the gate is open
    `GPTG_ASSERT_RST(a_fire_needs_gate, out_valid_reg |-> !(out_data_reg.fire_pulse && !out_data_reg.gate_is_on), "pulse fired with gate off")
    // a sweep never fires a pulse
    `GPTG_ASSERT_RST(a_sweep_no_fire, (out_valid_reg && out_data_reg.changed_mask != 3'b000) |-> !out_data_reg.fire_pulse, "pulse fired on a sweep")
    // period comes from the table range
    `GPTG_ASSERT_RST(a_period_range, out_valid_reg |-> (out_data_reg.period_ms >= PERIOD_MIN && out_data_reg.period_ms <= PERIOD_MAX), "period out of range")
    // a held result is not overwritten while the input stage is stalled
    `GPTG_ASSERT_ALWAYS(a_no_overrun, (aresetn && out_valid_reg && !m_tready && in_valid_reg) |-> !s_tready, "input taken while both stages are full")

endmodule
